// File: rtl/sne_pkg.sv
// shared constants and a character helper for the short name encoder
package sne_pkg;

    localparam int unsigned SLOT_COUNT = 11;
    localparam int unsigned BASE_LEN   = 8;
    localparam int unsigned EXT_LEN    = SLOT_COUNT - BASE_LEN;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned POS_W      = $clog2(SLOT_COUNT + 1);

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_D0    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_D9    = 8'h39;
    localparam logic [CHAR_W-1:0] CASE_DIFF  = CHAR_LO_A - CHAR_UP_A;

    localparam logic [1:0] DOT_RUN_ONE = 2'd1;
    localparam logic [1:0] DOT_RUN_TWO = 2'd2;
    localparam logic [1:0] DOT_RUN_MAX = 2'd3;

    typedef logic [CHAR_W-1:0] t_char;

    // uppercased letter or digit, nul when the byte is neither
    function automatic t_char keep_char(input t_char c);
        t_char res;
        res = CHAR_NUL;
        if (c inside {[CHAR_LO_A:CHAR_LO_Z]}) begin
            res = c - CASE_DIFF;
        end else if (c inside {[CHAR_UP_A:CHAR_UP_Z], [CHAR_D0:CHAR_D9]}) begin
            res = c;
        end
        return res;
    endfunction

endpackage

// File: rtl/short_name_encoder_core.sv
// short name encoder top level: byte stream in, 8.3 short name out
//
// Takes a file name one byte per request on the char channel and, on the nul
// byte that ends it, gives one request on the name channel carrying the eight
// base characters and three extension characters, space padded, first
// character in the most significant byte. Letters are uppercased, letters and
// digits are kept, everything else is dropped; the first dot switches from the
// base to the extension. A name that is exactly one or two dots comes out as
// "." or "..". The slot registers and counters update at the accepting edge
// and a finished name goes into an output register, so one byte per clock is
// sustained. The only stall on the char side is while the output register
// holds a name that the far side has not yet taken.
module short_name_encoder_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // char channel
    input  logic                                  i_char_valid,
    output logic                                  o_char_stall,
    input  logic [sne_pkg::CHAR_W-1:0]            i_char_in,
    // name channel
    output logic                                  o_name_valid,
    input  logic                                  i_name_stall,
    output logic [sne_pkg::BASE_LEN*sne_pkg::CHAR_W-1:0] o_base_part,
    output logic [sne_pkg::EXT_LEN*sne_pkg::CHAR_W-1:0]  o_ext_part
);
    import sne_pkg::*;

    // name state
    t_char             r_slots [SLOT_COUNT];
    t_char             n_slots [SLOT_COUNT];
    logic [POS_W-1:0]  r_slot_pos, n_slot_pos;
    logic              r_in_ext, n_in_ext;
    logic [1:0]        r_dot_run, n_dot_run;
    logic              r_non_dot, n_non_dot;

    // output register
    logic                          r_out_valid;
    logic [BASE_LEN*CHAR_W-1:0]    r_base, n_base;
    logic [EXT_LEN*CHAR_W-1:0]     r_ext, n_ext;

    logic   char_accept;
    logic   is_end;
    logic   is_dot;
    t_char  kept;
    logic   pos_ok;
    logic   dot_name;

    // stall only while a finished name waits
    assign o_char_stall = r_out_valid && i_name_stall;
    assign char_accept  = i_char_valid && !o_char_stall;
    assign is_end       = (i_char_in == CHAR_NUL);
    assign is_dot       = (i_char_in == CHAR_DOT);
    assign kept         = keep_char(i_char_in);
    assign pos_ok       = r_in_ext ? (r_slot_pos < POS_W'(SLOT_COUNT))
                                   : (r_slot_pos < POS_W'(BASE_LEN));
    // name made of one or two dots only
    assign dot_name     = !r_non_dot &&
                          ((r_dot_run == DOT_RUN_ONE) || (r_dot_run == DOT_RUN_TWO));

    // next name state for a non-nul byte
    always_comb begin
        n_slots    = r_slots;
        n_slot_pos = r_slot_pos;
        n_in_ext   = r_in_ext;
        n_dot_run  = r_dot_run;
        n_non_dot  = r_non_dot;
        if (is_dot) begin
            if (!r_non_dot && (r_dot_run != DOT_RUN_MAX)) begin
                n_dot_run = r_dot_run + 2'd1;
            end
        end else begin
            n_non_dot = 1'b1;
        end
        if (!r_in_ext && is_dot) begin
            // first dot: jump to the extension slots
            n_in_ext   = 1'b1;
            n_slot_pos = POS_W'(BASE_LEN);
        end else if ((kept != CHAR_NUL) && pos_ok) begin
            for (int k = 0; k < SLOT_COUNT; k++) begin
                if (r_slot_pos == POS_W'(k)) begin
                    n_slots[k] = kept;
                end
            end
            n_slot_pos = r_slot_pos + POS_W'(1);
        end
    end

    // packed result, with the dot names substituted
    always_comb begin
        for (int k = 0; k < BASE_LEN; k++) begin
            n_base[(BASE_LEN-1-k)*CHAR_W +: CHAR_W] = r_slots[k];
        end
        for (int k = 0; k < EXT_LEN; k++) begin
            n_ext[(EXT_LEN-1-k)*CHAR_W +: CHAR_W] = r_slots[BASE_LEN+k];
        end
        if (dot_name) begin
            n_base = {BASE_LEN{CHAR_SPACE}};
            n_ext  = {EXT_LEN{CHAR_SPACE}};
            n_base[(BASE_LEN-1)*CHAR_W +: CHAR_W] = CHAR_DOT;
            if (r_dot_run == DOT_RUN_TWO) begin
                n_base[(BASE_LEN-2)*CHAR_W +: CHAR_W] = CHAR_DOT;
            end
        end
    end

    // name state registers; a nul byte returns them to reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (char_accept && is_end)) begin
            for (int k = 0; k < SLOT_COUNT; k++) begin
                r_slots[k] <= CHAR_SPACE;
            end
            r_slot_pos <= '0;
            r_in_ext   <= 1'b0;
            r_dot_run  <= '0;
            r_non_dot  <= 1'b0;
        end else if (char_accept) begin
            r_slots    <= n_slots;
            r_slot_pos <= n_slot_pos;
            r_in_ext   <= n_in_ext;
            r_dot_run  <= n_dot_run;
            r_non_dot  <= n_non_dot;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (char_accept && is_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_name_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (char_accept && is_end) begin
            r_base <= n_base;
            r_ext  <= n_ext;
        end
    end

    assign o_name_valid = r_out_valid;
    assign o_base_part  = r_base;
    assign o_ext_part   = r_ext;

endmodule
